### src/ntsr_pkg.sv
package ntsr_pkg;

    localparam int NUM_W     = 32;
    localparam int UNITS_W   = 3;
    localparam int POINT_W   = 3;
    localparam int BYTE_W    = 8;
    localparam int BCD_W     = 4;

    // Binary bits folded into the BCD chain per clock.
    localparam int STEP_BITS = 4;
    localparam int STEPS     = NUM_W / STEP_BITS;
    localparam int STEP_W    = $clog2(STEPS);

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [BCD_W-1:0]     t_bcd;
    typedef logic [STEP_BITS-1:0] t_bits;

    localparam t_byte CMD_AUTO_INC = 8'h40;
    localparam t_byte ADDR_START   = 8'hC0;
    localparam t_byte POINT_BIT    = 8'h80;
    localparam t_byte SEG_BLANK    = 8'h00;

    localparam t_bcd BCD_ADJ_MIN = 4'd5;
    localparam t_bcd BCD_ADJ_ADD = 4'd3;

    function automatic t_byte seg_font(input t_bcd d);
        t_byte s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Ten to the power n, used only with constant arguments.
    function automatic logic [NUM_W-1:0] pow10(input int n);
        logic [NUM_W-1:0] p;
        p = NUM_W'(1);
        for (int k = 0; k < n; k++) begin
            p = p * NUM_W'(10);
        end
        return p;
    endfunction

endpackage

### src/ntsr_digit_cell.sv
module ntsr_digit_cell
    import ntsr_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_step,
    input  t_bits              i_bits,
    input  logic [NUM_W-1:0]   i_number,
    input  logic               i_pad,
    input  logic [POINT_W-1:0] i_point,
    output t_bits              o_bits,
    output t_byte              o_seg
);

    localparam logic [NUM_W-1:0] THRESH    = pow10(IDX);
    localparam logic             ALWAYS_ON = (IDX == 0);

    t_bcd r_digit;
    t_bcd n_digit;
    logic r_show;
    logic r_point;

    // Several shift-and-adjust steps of the double-dabble, most significant
    // incoming bit first. A new item starts from an all-zero digit.
    always_comb begin
        t_bcd d;
        t_bcd a;
        d = i_load ? '0 : r_digit;
        o_bits = '0;
        for (int j = STEP_BITS - 1; j >= 0; j--) begin
            a = (d >= BCD_ADJ_MIN) ? t_bcd'(d + BCD_ADJ_ADD) : d;
            o_bits[j] = a[BCD_W-1];
            d = {a[BCD_W-2:0], i_bits[j]};
        end
        n_digit = d;
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_digit <= n_digit;
        end
        if (i_load) begin
            r_show  <= ALWAYS_ON || i_pad || (i_number >= THRESH);
            r_point <= (i_point == POINT_W'(IDX));
        end
    end

    assign o_seg = (r_show ? seg_font(r_digit) : SEG_BLANK) | (r_point ? POINT_BIT : SEG_BLANK);

endmodule

### src/ntsr_out_chain.sv
module ntsr_out_chain
    import ntsr_pkg::*;
#(
    parameter int NB = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic [NB-1:0][BYTE_W-1:0] i_bytes,
    input  logic                     i_stall,
    output logic                     o_free,
    output logic                     o_valid,
    output t_byte                    o_data_byte,
    output logic                     o_frame_start,
    output logic                     o_frame_end,
    output logic                     o_last
);

    localparam int CW = $clog2(NB);
    localparam logic [CW-1:0] LAST_CNT = CW'(NB - 1);

    logic [NB-1:0][BYTE_W-1:0] r_bytes;
    logic [NB-1:0][BYTE_W-1:0] n_bytes;
    logic [CW-1:0]             r_cnt;
    logic [CW-1:0]             n_cnt;
    logic                      r_valid;
    logic                      n_valid;
    logic                      w_xfer;

    assign w_xfer = r_valid && !i_stall;
    assign o_free = !r_valid || (w_xfer && (r_cnt == LAST_CNT));

    always_comb begin
        n_bytes = r_bytes;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        if (i_load) begin
            n_bytes = i_bytes;
            n_cnt   = '0;
            n_valid = 1'b1;
        end else if (w_xfer) begin
            if (r_cnt == LAST_CNT) begin
                n_valid = 1'b0;
            end else begin
                n_bytes = r_bytes >> BYTE_W;
                n_cnt   = CW'(r_cnt + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
        r_bytes <= n_bytes;
    end

    assign o_valid       = r_valid;
    assign o_data_byte   = r_bytes[0];
    assign o_frame_start = (r_cnt == CW'(0)) || (r_cnt == CW'(1));
    assign o_frame_end   = (r_cnt == CW'(0)) || (r_cnt == LAST_CNT);
    assign o_last        = (r_cnt == LAST_CNT);

endmodule

### src/number_to_segments_right_aligned.sv
// Converts an unsigned 32-bit number into one display write transaction of
// DIGITS+2 bytes: the auto-increment command 0x40 as a frame of its own, then
// address 0xC0 and one segment byte per display position from position 0
// upward, the last of these closing the frame. The low DIGITS decimal digits
// are shown with the units digit at i_units_position, higher digits to its
// left, blanks to its right; leading zeros are blank unless i_pad_zeros is
// set, and the units digit always shows. Conversion runs in a row of BCD digit
// cells, one per decimal digit, which take four bits of the number per clock
// until all 32 bits are in. The finished segment bytes are then moved into
// an output byte chain while the row already takes the next item, so a new
// number can enter before the bytes of the previous one have left. A finished
// result waits in the row, and the input stalls, until the chain is free.
module number_to_segments_right_aligned
    import ntsr_pkg::*;
#(
    parameter int DIGITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [NUM_W-1:0]   i_number,
    input  logic [UNITS_W-1:0] i_units_position,
    input  logic [POINT_W-1:0] i_point_digit,
    input  logic               i_pad_zeros,
    output logic               o_valid,
    input  logic               i_stall,
    output t_byte              o_data_byte,
    output logic               o_frame_start,
    output logic               o_frame_end,
    output logic               o_last
);

    localparam int NB    = DIGITS + 2;
    localparam int SUM_W = UNITS_W + 1;

    // Conversion control: r_left counts the remaining four-bit steps.
    logic               r_busy;
    logic [STEP_W-1:0]  r_left;
    logic [NUM_W-1:0]   r_num;
    logic [UNITS_W-1:0] r_units;

    logic w_in_xfer;
    logic w_step;
    logic w_done;
    logic w_handoff;
    logic w_out_free;

    t_bits w_link [0:DIGITS];
    t_byte w_seg  [0:DIGITS-1];

    logic [NB-1:0][BYTE_W-1:0] w_bytes;

    assign w_in_xfer = i_valid && !o_stall;
    assign w_step    = w_in_xfer || (r_busy && (r_left != '0));
    assign w_done    = r_busy && (r_left == '0);
    assign w_handoff = w_done && w_out_free;

    // The row stays busy until its result moves on; a new item may enter on
    // the very edge at which the previous one is handed off.
    assign o_stall = r_busy && !w_handoff;

    // The first four bits enter the row on the transfer edge itself.
    assign w_link[0] = w_in_xfer ? i_number[NUM_W-1 -: STEP_BITS]
                                 : r_num[NUM_W-1 -: STEP_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else begin
            if (w_in_xfer) begin
                r_busy <= 1'b1;
                r_left <= STEP_W'(STEPS - 1);
            end else begin
                if (w_handoff) begin
                    r_busy <= 1'b0;
                end
                if (w_step) begin
                    r_left <= STEP_W'(r_left - 1'b1);
                end
            end
        end
        if (w_in_xfer) begin
            r_num   <= i_number << STEP_BITS;
            r_units <= i_units_position;
        end else if (w_step) begin
            r_num   <= r_num << STEP_BITS;
        end
    end

    // One cell per decimal digit; each passes the bits it shifts out of its
    // top to the next higher digit. Bits leaving the top cell are dropped,
    // which keeps only the low DIGITS digits.
    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        ntsr_digit_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_load  (w_in_xfer),
            .i_step  (w_step),
            .i_bits  (w_link[g]),
            .i_number(i_number),
            .i_pad   (i_pad_zeros),
            .i_point (i_point_digit),
            .o_bits  (w_link[g+1]),
            .o_seg   (w_seg[g])
        );
    end

    // Display position p shows decimal digit d where p + d equals the units
    // position; positions with no such digit stay blank.
    always_comb begin
        w_bytes    = '0;
        w_bytes[0] = CMD_AUTO_INC;
        w_bytes[1] = ADDR_START;
        for (int p = 0; p < DIGITS; p++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if ({1'b0, r_units} == SUM_W'(p + d)) begin
                    w_bytes[p+2] = w_seg[d];
                end
            end
        end
    end

    ntsr_out_chain #(
        .NB(NB)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_handoff),
        .i_bytes      (w_bytes),
        .i_stall      (i_stall),
        .o_free       (w_out_free),
        .o_valid      (o_valid),
        .o_data_byte  (o_data_byte),
        .o_frame_start(o_frame_start),
        .o_frame_end  (o_frame_end),
        .o_last       (o_last)
    );

endmodule

### src/ntsr_checker.sv
module ntsr_checker
    import ntsr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input t_byte              o_data_byte,
    input logic               o_frame_start,
    input logic               o_frame_end,
    input logic               o_last
);

    // The final byte of a transaction always closes its frame.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_frame_end && !o_frame_start))
        else $error("last byte without frame end");

    // A transaction that ends is followed, if at all, by a new command byte.
    a_next_is_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=>
        (!o_valid || (o_data_byte == CMD_AUTO_INC && o_frame_start && o_frame_end)))
        else $error("transaction not started by command byte");

    // The address byte comes right after the command byte, without a gap.
    a_cmd_then_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_frame_start && o_frame_end) |=>
        (o_valid && o_data_byte == ADDR_START && o_frame_start && !o_frame_end))
        else $error("address byte missing after command");

    // An accepted number occupies the conversion row for several cycles.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after a transfer");

endmodule

bind number_to_segments_right_aligned ntsr_checker u_ntsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_data_byte     (o_data_byte),
    .o_frame_start   (o_frame_start),
    .o_frame_end     (o_frame_end),
    .o_last          (o_last)
);

### test/display_write_checker.sv
module display_write_checker
    import ntsr_pkg::*;
#(
    parameter int DIGITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [NUM_W-1:0]   i_number,
    input  logic [UNITS_W-1:0] i_units_position,
    input  logic [POINT_W-1:0] i_point_digit,
    input  logic               i_pad_zeros,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_byte              i_data_byte,
    input  logic               i_frame_start,
    input  logic               i_frame_end,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_byte data;
        logic  frame_start;
        logic  frame_end;
        logic  last;
    } t_display_byte;

    // Segment patterns for decimal digits 9 down to 0.
    localparam logic [9:0][7:0] DIGIT_SEGMENTS = {
        8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
    };

    t_display_byte expected_bytes[$];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_bytes_checked = 0;
    end

    // Builds the full write transaction that one number should produce.
    function automatic void queue_display_write(
        input logic [NUM_W-1:0]   number,
        input logic [UNITS_W-1:0] units,
        input logic [POINT_W-1:0] point,
        input logic               pad
    );
        t_byte            digit_seg [DIGITS];
        logic [NUM_W-1:0] rest;
        int               sig_digits;
        int               offset;
        t_byte            seg;
        rest       = number;
        sig_digits = 0;
        while (rest != 0 && sig_digits < DIGITS) begin
            sig_digits++;
            rest = rest / 10;
        end
        // Zero still shows its units digit.
        if (sig_digits == 0) begin
            sig_digits = 1;
        end
        rest = number;
        for (int i = 0; i < DIGITS; i++) begin
            seg = SEG_BLANK;
            if (i < sig_digits || pad) begin
                seg = DIGIT_SEGMENTS[rest % 10];
            end
            if (int'(point) == i) begin
                seg = seg | POINT_BIT;
            end
            digit_seg[i] = seg;
            rest = rest / 10;
        end
        expected_bytes.push_back(t_display_byte'{CMD_AUTO_INC, 1'b1, 1'b1, 1'b0});
        expected_bytes.push_back(t_display_byte'{ADDR_START, 1'b1, 1'b0, 1'b0});
        for (int pos = 0; pos < DIGITS; pos++) begin
            seg    = SEG_BLANK;
            offset = int'(units) - pos;
            if (offset >= 0 && offset < DIGITS) begin
                seg = digit_seg[offset];
            end
            expected_bytes.push_back(t_display_byte'{seg, 1'b0,
                                                     pos == DIGITS - 1,
                                                     pos == DIGITS - 1});
        end
    endfunction

    function automatic bit field_ok(input string field, input int unsigned want,
                                    input int unsigned got);
        if (want == got) begin
            return 1'b1;
        end
        $display("time %0t: %s mismatch on display byte %0d: expected 'h%0h, got 'h%0h",
                 $time, field, o_bytes_checked, want, got);
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : compare_proc
        t_display_byte want;
        bit            good;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                queue_display_write(i_number, i_units_position, i_point_digit,
                                    i_pad_zeros);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $display("time %0t: display byte 'h%0h arrived with nothing expected",
                             $time, i_data_byte);
                    o_fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    good = field_ok("data_byte", want.data, i_data_byte)
                         & field_ok("frame_start", want.frame_start, i_frame_start)
                         & field_ok("frame_end", want.frame_end, i_frame_end)
                         & field_ok("last", want.last, i_last);
                    if (!good) begin
                        o_fail_count++;
                    end
                end
                o_bytes_checked++;
            end
            o_pending = expected_bytes.size();
        end
    end

endmodule

### test/tb_number_to_segments_right_aligned.sv
module tb_number_to_segments_right_aligned;
    import ntsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS       = 6;
    localparam int RANDOM_ITEMS = 88;
    // Idle time after the final drain, so that anything stray the block might
    // still send is caught.
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    // The receiver cycles through these back-pressure styles over the run.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [NUM_W-1:0]   i_number;
    logic [UNITS_W-1:0] i_units_position;
    logic [POINT_W-1:0] i_point_digit;
    logic               i_pad_zeros;
    logic               o_valid;
    logic               i_stall = 1'b0;
    t_byte              o_data_byte;
    logic               o_frame_start;
    logic               o_frame_end;
    logic               o_last;

    int fail_count;
    int pending_bytes;
    int bytes_checked;
    int numbers_sent   = 0;
    int stall_cycle    = 0;
    int cycle_count    = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    number_to_segments_right_aligned #(
        .DIGITS(DIGITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_number        (i_number),
        .i_units_position(i_units_position),
        .i_point_digit   (i_point_digit),
        .i_pad_zeros     (i_pad_zeros),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_data_byte     (o_data_byte),
        .o_frame_start   (o_frame_start),
        .o_frame_end     (o_frame_end),
        .o_last          (o_last)
    );

    // The checker sits beside the block, watches both channels, predicts
    // every byte of every write transaction and counts mismatches.
    display_write_checker #(
        .DIGITS(DIGITS)
    ) display_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_number        (i_number),
        .i_units_position(i_units_position),
        .i_point_digit   (i_point_digit),
        .i_pad_zeros     (i_pad_zeros),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_data_byte     (o_data_byte),
        .i_frame_start   (o_frame_start),
        .i_frame_end     (o_frame_end),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending_bytes),
        .o_bytes_checked (bytes_checked)
    );

    // Receiver back-pressure. The style steps through the four modes in turn so
    // that stalls land on every byte of a transaction, with long stretches of
    // no stall at all in between.
    always @(negedge i_clk) begin
        t_stall_mode mode;
        mode = t_stall_mode'((stall_cycle / 150) % 4);
        stall_cycle <= stall_cycle + 1;
        case (mode)
            STALL_NONE: begin
                i_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
                i_stall <= ($urandom_range(0, 9) < 6);
            end
            default: begin
                i_stall <= ((stall_cycle % 7) < 3);
            end
        endcase
    end

    // Watchdog. A hang or a missing byte ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Offers one number and holds it until the block takes it. Valid stays
    // high into the next call, so back-to-back transfers need no gap.
    task automatic send_display(input logic [NUM_W-1:0]   number,
                                input logic [UNITS_W-1:0] units,
                                input logic [POINT_W-1:0] point,
                                input logic               pad);
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_number         <= number;
        i_units_position <= units;
        i_point_digit    <= point;
        i_pad_zeros      <= pad;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        numbers_sent++;
    endtask

    // Sender gap of a given number of cycles with valid low.
    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Drops valid and waits until every predicted byte has been received.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending_bytes == 0);
    endtask

    initial begin : stimulus
        int               random_sent;
        int               burst;
        logic [NUM_W-1:0] num;
        logic [UNITS_W-1:0] units;

        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_number         = '0;
        i_units_position = '0;
        i_point_digit    = '0;
        i_pad_zeros      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed numbers. Zero must still show its units digit, with and
        // without padding and with the point on it.
        send_display(32'd0, 3'd0, 3'd7, 1'b0);
        send_display(32'd0, 3'd5, 3'd6, 1'b1);
        send_display(32'd0, 3'd3, 3'd0, 1'b0);
        hold_off($urandom_range(0, 2));
        // Largest value: digits above the sixth are dropped.
        send_display(32'hFFFF_FFFF, 3'd5, 3'd7, 1'b0);
        send_display(32'hFFFF_FFFF, 3'd5, 3'd2, 1'b1);
        send_display(32'd999999, 3'd5, 3'd5, 1'b0);
        // One million: the shown six digits are all zero but still count as
        // significant, so they show even without padding.
        send_display(32'd1000000, 3'd5, 3'd6, 1'b0);
        hold_off($urandom_range(0, 2));
        // Units digit moved around; higher digits fall off the left edge.
        send_display(32'd123456, 3'd5, 3'd0, 1'b0);
        send_display(32'd123456, 3'd2, 3'd3, 1'b0);
        send_display(32'd123456, 3'd0, 3'd1, 1'b1);
        // Point on a blanked leading position.
        send_display(32'd42, 3'd5, 3'd4, 1'b0);
        send_display(32'd42, 3'd3, 3'd2, 1'b1);
        hold_off($urandom_range(0, 2));
        // Units position beyond the display: everything goes blank or shifts.
        send_display(32'd7, 3'd6, 3'd0, 1'b0);
        send_display(32'd7, 3'd7, 3'd6, 1'b1);
        send_display(32'd305, 3'd4, 3'd1, 1'b0);
        send_display(32'd10, 3'd5, 3'd0, 1'b0);
        send_display(32'd100000, 3'd1, 3'd5, 1'b0);
        send_display(32'd5, 3'd0, 3'd0, 1'b1);
        hold_off($urandom_range(0, 2));
        send_display(32'hAAAA_AAAA, 3'd5, 3'd3, 1'b0);
        send_display(32'h5555_5555, 3'd4, 3'd4, 1'b1);
        send_display(32'd9, 3'd5, 3'd5, 1'b1);

        // Random numbers in bursts. Sizes are mixed so that blanking of
        // leading zeros shows up at every width.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 30)
                                                : $urandom_range(1, 8);
            for (int n = 0; n < burst && random_sent < RANDOM_ITEMS; n++) begin
                case ($urandom_range(0, 4))
                    0: num = $urandom_range(0, 9);
                    1: num = $urandom_range(0, 9999);
                    2: num = $urandom_range(0, 999999);
                    3: num = $urandom();
                    default: begin
                        num = $urandom_range(1, 9);
                        repeat ($urandom_range(0, 9)) num = num * 10;
                    end
                endcase
                units = ($urandom_range(0, 7) == 0) ? UNITS_W'($urandom_range(6, 7))
                                                    : UNITS_W'($urandom_range(0, 5));
                send_display(num, units, POINT_W'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)));
                random_sent++;
                // Halfway through, let the block run completely empty once.
                if (random_sent == RANDOM_ITEMS / 2) begin
                    wait_drained();
                end
            end
            hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d numbers (%0d random) and checked %0d display bytes,",
                 numbers_sent, random_sent, bytes_checked);
        $display("with sender bursts and gaps, a full drain and four receiver stall styles.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
src/ntsr_pkg.sv
src/ntsr_digit_cell.sv
src/ntsr_out_chain.sv
src/number_to_segments_right_aligned.sv
src/ntsr_checker.sv
test/display_write_checker.sv
test/tb_number_to_segments_right_aligned.sv
